FILE: rtl/core/pmfb_pkg.sv
package pmfb_pkg;

	// default panel geometry
	localparam int PANEL_WIDTH_DEF  = 128;
	localparam int PANEL_HEIGHT_DEF = 64;

	// pixels held in one store byte
	localparam int PIX_PER_BYTE = 8;

	// fill patterns
	localparam logic [7:0] FILL_ONES  = 8'hFF;
	localparam logic [7:0] FILL_ZEROS = 8'h00;

	// operation codes carried on the mode field
	typedef enum logic [2:0] {
		MODE_SET_PIXEL  = 3'd0,
		MODE_PAGE_WRITE = 3'd1,
		MODE_READ_PIXEL = 3'd2,
		MODE_FILL       = 3'd3,
		MODE_READ_BYTE  = 3'd4
	} mode_t;

	// controller to datapath
	typedef struct packed {
		logic take;        // capture item, read its byte
		logic mod_a;       // modify and write the first byte
		logic rd_b;        // read the spill byte on the next page
		logic mod_b;       // modify and write the spill byte
		logic sweep_en;    // write one byte of a whole-store sweep
		logic sweep_ones;  // sweep writes the fill value rather than zeros
		logic load_out;    // load the result register
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_fill;     // offered item is a fill
		logic spill;       // captured page write spills into the next page
		logic sweep_last;  // sweep is at the last byte
		logic out_free;    // result register can take a new result
	} dp_status_t;

	// index width for n entries, at least one bit
	function automatic int idx_width(input int n);
		idx_width = (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage

FILE: rtl/core/pmfb_ctrl.sv
module pmfb_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  pmfb_pkg::dp_status_t  status,
	output pmfb_pkg::ctrl_cmd_t   cmd
);
	import pmfb_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD_A,
		ST_MOD_B,
		ST_FILL,
		ST_DONE
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (status.sweep_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid) state_q <= status.in_fill ? ST_FILL : ST_MOD_A;
				end
				ST_MOD_A: begin
					if (status.spill)        state_q <= ST_MOD_B;
					else if (status.out_free) state_q <= ST_IDLE;
					else                      state_q <= ST_DONE;
				end
				ST_MOD_B: begin
					state_q <= status.out_free ? ST_IDLE : ST_DONE;
				end
				ST_FILL: begin
					if (status.sweep_last) state_q <= status.out_free ? ST_IDLE : ST_DONE;
				end
				ST_DONE: begin
					if (status.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd            = '0;
		cmd.take       = (state_q == ST_IDLE) && in_valid;
		cmd.mod_a      = (state_q == ST_MOD_A);
		cmd.rd_b       = (state_q == ST_MOD_A) && status.spill;
		cmd.mod_b      = (state_q == ST_MOD_B);
		cmd.sweep_en   = (state_q == ST_CLEAR) || (state_q == ST_FILL);
		cmd.sweep_ones = (state_q == ST_FILL);
		unique case (state_q)
			ST_MOD_A: cmd.load_out = !status.spill && status.out_free;
			ST_MOD_B: cmd.load_out = status.out_free;
			ST_FILL:  cmd.load_out = status.sweep_last && status.out_free;
			ST_DONE:  cmd.load_out = status.out_free;
			default:  cmd.load_out = 1'b0;
		endcase
	end

endmodule

FILE: rtl/core/pmfb_datapath.sv
module pmfb_datapath #(
	parameter int PANEL_WIDTH  = pmfb_pkg::PANEL_WIDTH_DEF,
	parameter int PANEL_HEIGHT = pmfb_pkg::PANEL_HEIGHT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [2:0]            mode,
	input  logic signed [15:0]    x,
	input  logic signed [15:0]    y,
	input  logic [7:0]            pattern,
	input  logic                  turn_on,
	input  pmfb_pkg::ctrl_cmd_t   cmd,
	output pmfb_pkg::dp_status_t  status,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic                  pixel_value,
	output logic [7:0]            read_byte
);
	import pmfb_pkg::*;

	localparam int PAGE_COUNT = PANEL_HEIGHT / PIX_PER_BYTE;
	localparam int ROWS_USED  = PAGE_COUNT * PIX_PER_BYTE;
	localparam int STORE_SIZE = PANEL_WIDTH * PAGE_COUNT;
	localparam int ADDR_W     = idx_width(STORE_SIZE);
	localparam int PAGE_W     = idx_width(PAGE_COUNT);
	localparam int COL_W      = idx_width(PANEL_WIDTH);
	localparam logic [ADDR_W-1:0] WIDTH_A   = ADDR_W'(PANEL_WIDTH);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_SIZE - 1);

	// decode of the offered item
	logic              x_ok, y_ok, pg_ok, ok_in, spill_in;
	logic [PAGE_W-1:0] page_in;
	logic [ADDR_W-1:0] addr_in;

	// captured item
	logic [2:0]        mode_q;
	logic              ok_q, spill_q, on_q;
	logic [2:0]        off_q;
	logic [7:0]        pattern_q;
	logic [ADDR_W-1:0] addr_q;

	logic [7:0]        pixel_store_q [STORE_SIZE];
	logic [7:0]        rdata_q;
	logic [ADDR_W-1:0] sweep_q;
	logic              out_valid_q, pixel_value_q;
	logic [7:0]        read_byte_q;

	logic [ADDR_W-1:0] addr_b, rd_addr, wr_addr;
	logic [7:0]        wr_data, new_byte, bits_sel;
	logic [15:0]       bits_wide;
	logic              wr_en, res_pix;
	logic [7:0]        res_byte;

	always_comb begin
		x_ok    = !x[15] && ($unsigned(x) < 16'(PANEL_WIDTH));
		y_ok    = !y[15] && ($unsigned(y) < 16'(ROWS_USED));
		pg_ok   = !y[15] && ($unsigned(y) < 16'(PAGE_COUNT));
		ok_in   = x_ok && ((mode == MODE_READ_BYTE) ? pg_ok : y_ok);
		page_in = (mode == MODE_READ_BYTE) ? y[PAGE_W-1:0] : y[PAGE_W+2:3];
		addr_in = ADDR_W'(ADDR_W'(page_in) * WIDTH_A) + ADDR_W'(x[COL_W-1:0]);
		spill_in = (mode == MODE_PAGE_WRITE) && ok_in && (y[2:0] != 3'd0)
			&& ((int'(page_in) + 1) < PAGE_COUNT);
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			mode_q    <= mode;
			ok_q      <= ok_in;
			spill_q   <= spill_in;
			on_q      <= turn_on;
			off_q     <= y[2:0];
			pattern_q <= pattern;
			addr_q    <= addr_in;
		end
	end

	// pattern shifted to its row; upper half spills into the next page
	always_comb begin
		if (mode_q == MODE_SET_PIXEL) bits_wide = 16'd1 << off_q;
		else                          bits_wide = {8'd0, pattern_q} << off_q;
		bits_sel = cmd.mod_b ? bits_wide[15:8] : bits_wide[7:0];
		new_byte = on_q ? (rdata_q | bits_sel) : (rdata_q & ~bits_sel);
	end

	assign addr_b  = addr_q + WIDTH_A;
	assign rd_addr = cmd.rd_b ? addr_b : addr_in;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_q;
		wr_data = new_byte;
		if (cmd.sweep_en) begin
			wr_en   = 1'b1;
			wr_addr = sweep_q;
			wr_data = (cmd.sweep_ones && on_q) ? FILL_ONES : FILL_ZEROS;
		end else if (cmd.mod_b) begin
			wr_en   = 1'b1;
			wr_addr = addr_b;
		end else if (cmd.mod_a) begin
			wr_en   = ok_q && ((mode_q == MODE_SET_PIXEL) || (mode_q == MODE_PAGE_WRITE));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take || cmd.rd_b) rdata_q <= pixel_store_q[rd_addr];
		if (wr_en) pixel_store_q[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.sweep_en) begin
			sweep_q <= (sweep_q == LAST_ADDR) ? '0 : sweep_q + 1'b1;
		end
	end

	// result of the captured item; read data holds until the next read
	assign res_pix  = ok_q && (mode_q == MODE_READ_PIXEL) && rdata_q[off_q];
	assign res_byte = (ok_q && (mode_q == MODE_READ_BYTE)) ? rdata_q : 8'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			pixel_value_q <= res_pix;
			read_byte_q   <= res_byte;
		end
	end

	assign status.in_fill    = (mode == MODE_FILL);
	assign status.spill      = spill_q;
	assign status.sweep_last = (sweep_q == LAST_ADDR);
	assign status.out_free   = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign pixel_value = pixel_value_q;
	assign read_byte   = read_byte_q;

endmodule

FILE: rtl/core/paged_mono_framebuffer.sv
// one-bit-per-pixel frame store of PANEL_WIDTH columns by PANEL_HEIGHT rows, held as
// PANEL_HEIGHT/8 pages of one byte per column, bit 0 the topmost pixel of the byte.
// each input item gives exactly one result item: the pixel for a pixel read, the raw
// byte for a byte read (y is then the page), zeros otherwise; coordinates off the
// panel change nothing and read as 0; a fill ignores them. the store is a single memory
// with one write port and one registered read port, so an item costs a read then a
// modify-write: set, clear and read items take a read and one modify step, an unaligned
// page write that spills into the next page adds a read and modify-write of that byte,
// and a fill walks every byte of the store. after reset a clearing pass zeroes the store
// with in_ready low. the result register lets the next item be taken while a result
// still waits on out_ready. PANEL_HEIGHT must be a multiple of 8; rows of an incomplete
// last page count as off the panel
module paged_mono_framebuffer #(
	parameter int PANEL_WIDTH  = pmfb_pkg::PANEL_WIDTH_DEF,
	parameter int PANEL_HEIGHT = pmfb_pkg::PANEL_HEIGHT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// item in
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         mode,
	input  logic signed [15:0] x,
	input  logic signed [15:0] y,
	input  logic [7:0]         pattern,
	input  logic               turn_on,
	// result out
	output logic               out_valid,
	input  logic               out_ready,
	output logic               pixel_value,
	output logic [7:0]         read_byte
);
	import pmfb_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// sequencing: clearing pass, read, modify-write, spill, fill sweep, result hold
	pmfb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// address decode, store memory, byte merge and result register
	pmfb_datapath #(
		.PANEL_WIDTH  (PANEL_WIDTH),
		.PANEL_HEIGHT (PANEL_HEIGHT)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.mode        (mode),
		.x           (x),
		.y           (y),
		.pattern     (pattern),
		.turn_on     (turn_on),
		.cmd         (cmd),
		.status      (status),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.pixel_value (pixel_value),
		.read_byte   (read_byte)
	);

endmodule

FILE: rtl/core/pmfb_checker.sv
module pmfb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       pixel_value,
	input logic [7:0] read_byte
);

	// a result waiting on the consumer stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(pixel_value) && $stable(read_byte))
		else $error("result payload changed while stalled");

	// a pixel read and a byte read never share a result
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(pixel_value && (read_byte != 8'd0)))
		else $error("pixel and byte both set in one result");

	// in_ready is low in the cycle after an item is taken
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item taken on consecutive cycles");

endmodule

bind paged_mono_framebuffer pmfb_checker u_pmfb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.pixel_value (pixel_value),
	.read_byte   (read_byte)
);
